// File: rtl/pcsp_pkg.sv
// ----------------------------------------------------------------------------
// PNG chunk stream parser package
// Transfer types, parser state, phase and error codes, and the signature and
// IHDR tag tables shared by the parser modules.
// ----------------------------------------------------------------------------
package pcsp_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic        idat_valid;
      logic [7:0]  idat_byte;
      logic [31:0] payload_index;
      logic        header_ok;
      logic        end_found;
      logic [3:0]  error_code;
      logic [31:0] frame_width;
      logic [31:0] frame_height;
      logic [1:0]  colour_mode;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_SIG       = 4'd0,
      PH_TAG       = 4'd1,
      PH_WIDTH     = 4'd2,
      PH_HEIGHT    = 4'd3,
      PH_DEPTH     = 4'd4,
      PH_COLOUR    = 4'd5,
      PH_COMP      = 4'd6,
      PH_FILTER    = 4'd7,
      PH_INTERLACE = 4'd8,
      PH_CRC       = 4'd9,
      PH_CLEN      = 4'd10,
      PH_CNAME     = 4'd11,
      PH_IDAT      = 4'd12,
      PH_SKIP      = 4'd13,
      PH_DONE      = 4'd14
   } phase_type;

   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_SIGNATURE   = 4'd1;
   localparam logic [3:0] ERR_IHDR_TAG    = 4'd2;
   localparam logic [3:0] ERR_WIDTH       = 4'd3;
   localparam logic [3:0] ERR_HEIGHT      = 4'd4;
   localparam logic [3:0] ERR_DEPTH       = 4'd5;
   localparam logic [3:0] ERR_COLOUR      = 4'd6;
   localparam logic [3:0] ERR_COMPRESSION = 4'd7;
   localparam logic [3:0] ERR_FILTER      = 4'd8;
   localparam logic [3:0] ERR_INTERLACE   = 4'd9;

   localparam logic [31:0] NAME_IDAT    = 32'h4944_4154;
   localparam logic [31:0] NAME_IEND    = 32'h4945_4E44;
   localparam logic [7:0]  NEEDED_DEPTH = 8'd8;
   localparam logic [31:0] COUNT_TOP    = 32'hFFFF_FFFF;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] pos;
      logic [31:0] clen;
      logic [31:0] cname;
      logic [31:0] width;
      logic [31:0] height;
      logic [1:0]  colour;
      logic [3:0]  error;
      logic [31:0] pcount;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:  PH_SIG,
      pos:    32'd0,
      clen:   32'd0,
      cname:  32'd0,
      width:  32'd0,
      height: 32'd0,
      colour: 2'd0,
      error:  ERR_NONE,
      pcount: 32'd0
   };

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'd137;
         3'd1:    val = 8'd80;
         3'd2:    val = 8'd78;
         3'd3:    val = 8'd71;
         3'd4:    val = 8'd13;
         3'd5:    val = 8'd10;
         3'd6:    val = 8'd26;
         3'd7:    val = 8'd10;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

   // IHDR length (13) followed by the name
   function automatic logic [7:0] tag_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'd0;
         3'd1:    val = 8'd0;
         3'd2:    val = 8'd0;
         3'd3:    val = 8'd13;
         3'd4:    val = 8'd73;
         3'd5:    val = 8'd72;
         3'd6:    val = 8'd68;
         3'd7:    val = 8'd82;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/pcsp_step.sv
// ----------------------------------------------------------------------------
// PNG chunk stream parser byte step
// Next parser state and the result item for one file byte.
// ----------------------------------------------------------------------------
module pcsp_step import pcsp_pkg::*; (
   input  state_type cur,
   input  req_type   data,
   output state_type nxt,
   output rsp_type   rsp
);

   state_type   base;
   logic [7:0]  b;
   logic [31:0] shifted_len;
   logic [31:0] shifted_name;
   logic [31:0] pos_inc;
   logic        last_of_four;
   logic        last_of_eight;
   logic        fwd;
   logic [31:0] idx;

   always_comb begin
      base          = data.start_of_file ? STATE_RESET : cur;
      b             = data.file_byte;
      shifted_len   = {base.clen[23:0], b};
      shifted_name  = {base.cname[23:0], b};
      pos_inc       = base.pos + 32'd1;
      last_of_four  = (base.pos >= 32'd3);
      last_of_eight = (base.pos >= 32'd7);
      nxt           = base;
      fwd           = 1'b0;
      idx           = 32'd0;

      // first error and end of file both freeze the parser
      if (base.error == ERR_NONE && base.phase != PH_DONE) begin
         case (base.phase)
            PH_SIG: begin
               if (b != sig_byte(base.pos[2:0])) begin
                  nxt.error = ERR_SIGNATURE;
               end else if (last_of_eight) begin
                  nxt.phase = PH_TAG;
                  nxt.pos   = 32'd0;
               end else begin
                  nxt.pos = pos_inc;
               end
            end
            PH_TAG: begin
               if (b != tag_byte(base.pos[2:0])) begin
                  nxt.error = ERR_IHDR_TAG;
               end else if (last_of_eight) begin
                  nxt.phase = PH_WIDTH;
                  nxt.pos   = 32'd0;
               end else begin
                  nxt.pos = pos_inc;
               end
            end
            PH_WIDTH: begin
               nxt.clen = shifted_len;
               if (!last_of_four) begin
                  nxt.pos = pos_inc;
               end else begin
                  nxt.width = shifted_len;
                  if (shifted_len == 32'd0) begin
                     nxt.error = ERR_WIDTH;
                  end else begin
                     nxt.phase = PH_HEIGHT;
                     nxt.pos   = 32'd0;
                  end
               end
            end
            PH_HEIGHT: begin
               nxt.clen = shifted_len;
               if (!last_of_four) begin
                  nxt.pos = pos_inc;
               end else begin
                  nxt.height = shifted_len;
                  if (shifted_len == 32'd0) begin
                     nxt.error = ERR_HEIGHT;
                  end else begin
                     nxt.phase = PH_DEPTH;
                     nxt.pos   = 32'd0;
                  end
               end
            end
            PH_DEPTH: begin
               if (b != NEEDED_DEPTH) begin
                  nxt.error = ERR_DEPTH;
               end else begin
                  nxt.phase = PH_COLOUR;
                  nxt.pos   = 32'd0;
               end
            end
            PH_COLOUR: begin
               if (b inside {8'd0, 8'd2}) begin
                  nxt.colour = b[1:0];
                  nxt.phase  = PH_COMP;
                  nxt.pos    = 32'd0;
               end else begin
                  nxt.error = ERR_COLOUR;
               end
            end
            PH_COMP: begin
               if (b != 8'd0) begin
                  nxt.error = ERR_COMPRESSION;
               end else begin
                  nxt.phase = PH_FILTER;
                  nxt.pos   = 32'd0;
               end
            end
            PH_FILTER: begin
               if (b != 8'd0) begin
                  nxt.error = ERR_FILTER;
               end else begin
                  nxt.phase = PH_INTERLACE;
                  nxt.pos   = 32'd0;
               end
            end
            PH_INTERLACE: begin
               if (b > 8'd1) begin
                  nxt.error = ERR_INTERLACE;
               end else begin
                  nxt.phase = PH_CRC;
                  nxt.pos   = 32'd0;
               end
            end
            PH_CRC: begin
               if (last_of_four) begin
                  nxt.phase = PH_CLEN;
                  nxt.pos   = 32'd0;
               end else begin
                  nxt.pos = pos_inc;
               end
            end
            PH_CLEN: begin
               nxt.clen = shifted_len;
               if (last_of_four) begin
                  nxt.phase = PH_CNAME;
                  nxt.pos   = 32'd0;
               end else begin
                  nxt.pos = pos_inc;
               end
            end
            PH_CNAME: begin
               nxt.cname = shifted_name;
               if (!last_of_four) begin
                  nxt.pos = pos_inc;
               end else begin
                  nxt.pos = 32'd0;
                  // IEND wins over length; empty chunks go straight to CRC
                  if (shifted_name == NAME_IEND) begin
                     nxt.phase = PH_DONE;
                  end else if (base.clen == 32'd0) begin
                     nxt.phase = PH_CRC;
                  end else if (shifted_name == NAME_IDAT) begin
                     nxt.phase = PH_IDAT;
                  end else begin
                     nxt.phase = PH_SKIP;
                  end
               end
            end
            PH_IDAT, PH_SKIP: begin
               if (base.phase == PH_IDAT) begin
                  fwd = 1'b1;
                  idx = base.pcount;
                  if (base.pcount != COUNT_TOP) begin
                     nxt.pcount = base.pcount + 32'd1;
                  end
               end
               if (pos_inc >= base.clen) begin
                  nxt.phase = PH_CRC;
                  nxt.pos   = 32'd0;
               end else begin
                  nxt.pos = pos_inc;
               end
            end
            default: begin
            end
         endcase
      end

      rsp.idat_valid    = fwd;
      rsp.idat_byte     = fwd ? b : 8'd0;
      rsp.payload_index = idx;
      rsp.header_ok     = (nxt.error == ERR_NONE) && (nxt.phase >= PH_CRC);
      rsp.end_found     = (nxt.phase == PH_DONE);
      rsp.error_code    = nxt.error;
      rsp.frame_width   = nxt.width;
      rsp.frame_height  = nxt.height;
      rsp.colour_mode   = nxt.colour;
   end

endmodule

// File: rtl/png_chunk_stream_parser.sv
// ----------------------------------------------------------------------------
// PNG chunk stream parser
// Byte-wide PNG front end: header checks and IDAT payload extraction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one file byte per transfer; start_of_file marks byte 0 of a
//   new file and restarts the parser on that byte.
//   rsp channel: exactly one result per request byte, in order. idat_valid
//   flags forwarded IDAT payload with its offset in the IDAT data; the header
//   fields, header_ok, end_found and the sticky error code ride along.
//   Path: an accepted byte is held in the input register, then the parse step
//   writes its result into the result register.
//   Throughput: one byte per cycle while rsp_ready stays high; the combinational
//   parse step, whose state feeds back into itself, sets the rate.
//   Reset: both stages empty, parser back in the signature phase with all
//   stored fields and the payload count cleared.
//   Stall: while rsp_ready is low the result holds; one more byte can still
//   be taken into the input register before req_ready drops.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser import pcsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic      in_valid_ff;
   req_type   in_data_ff;
   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   rsp_type   out_data_in;
   logic      out_load;

   pcsp_step u_step (
      .cur  (state_ff),
      .data (in_data_ff),
      .nxt  (state_in),
      .rsp  (out_data_in)
   );

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // a held input byte is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff)
      else $error("input byte lost while result stage stalled");

   // parser state moves only when a byte is parsed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(state_ff))
      else $error("parser state changed without a parsed byte");

   a_ok_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.header_ok && rsp_payload.error_code != ERR_NONE))
      else $error("header_ok with an error code");

   a_end_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_found |-> rsp_payload.header_ok)
      else $error("end_found without a good header");

   a_idat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.idat_valid |->
         rsp_payload.idat_byte == 8'd0 && rsp_payload.payload_index == 32'd0)
      else $error("payload fields nonzero on a non-IDAT result");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      out_load && !in_data_ff.start_of_file |->
         state_in.pcount == state_ff.pcount || state_in.pcount == state_ff.pcount + 32'd1)
      else $error("payload count jumped");

endmodule
